// File: hdl/sd32_pkg.sv
package sd32_pkg;

    localparam int WIDTH = 32;

    typedef struct packed {
        logic signed [WIDTH-1:0] dividend;
        logic signed [WIDTH-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic signed [WIDTH-1:0] quotient;
        logic signed [WIDTH-1:0] remainder;
        logic                    divide_by_zero;
    } t_out;

    // Data handed from one pipeline stage to the next.
    typedef struct packed {
        logic             valid;
        logic             a_neg;   // dividend negative: remainder takes its sign
        logic             q_neg;   // operand signs differ: quotient negated
        logic             dz;      // divisor was zero
        logic [WIDTH-1:0] rem;     // partial remainder
        logic [WIDTH-1:0] quo;     // dividend bits out at the top, quotient bits in below
        logic [WIDTH-1:0] div;     // divisor magnitude
    } t_stage;

endpackage

// File: hdl/signed_divider_32bit.sv
// Result strobe o_valid follows the transfer through the pre, cell and post registers.
// Throughput: one division per cycle, set by the WIDTH restoring cells in the row.
// busy is held low; the receiver cannot stall, so results are never held back.
// Reset: synchronous active-low i_rst_n clears every stage valid; in-flight work drops.
module signed_divider_32bit
    import sd32_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output logic o_valid,
    output t_out o_data
);

    // Stage 0 holds magnitudes and sign flags; stages 1..WIDTH are the
    // divider cells, each settling one quotient bit, MSB first.
    t_stage w_stage [0:WIDTH];
    logic   w_load;

    // No back-pressure anywhere: a new transfer is taken every cycle.
    assign busy   = 1'b0;
    assign w_load = start && !busy;

    sd32_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (i_data),
        .o_stage (w_stage[0])
    );

    genvar g;
    generate
        for (g = 0; g < WIDTH; g++) begin : g_cell
            sd32_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_stage (w_stage[g]),
                .o_stage (w_stage[g+1])
            );
        end
    endgenerate

    // Sign correction and divide-by-zero zeroing, then the output register.
    sd32_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage[WIDTH]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// File: hdl/sd32_pre.sv
module sd32_pre
    import sd32_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_in    i_data,
    output t_stage o_stage
);

    logic             r_valid;
    t_stage           r_data;
    t_stage           n_data;
    logic [WIDTH-1:0] w_a;
    logic [WIDTH-1:0] w_b;

    assign w_a = i_data.dividend;
    assign w_b = i_data.divisor;

    always_comb begin
        n_data       = '0;
        n_data.a_neg = w_a[WIDTH-1];
        n_data.q_neg = w_a[WIDTH-1] ^ w_b[WIDTH-1];
        n_data.dz    = (w_b == '0);
        n_data.rem   = '0;
        // most negative value maps onto 2^(WIDTH-1), which fits unsigned
        n_data.quo   = w_a[WIDTH-1] ? (~w_a + 1'b1) : w_a;
        n_data.div   = w_b[WIDTH-1] ? (~w_b + 1'b1) : w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_stage       = r_data;
        o_stage.valid = r_valid;
    end

endmodule

// File: hdl/sd32_cell.sv
module sd32_cell
    import sd32_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    logic           r_valid;
    t_stage         r_data;
    t_stage         n_data;
    logic [WIDTH:0] w_shift;
    logic [WIDTH:0] w_diff;

    // one restoring step: shift in the next dividend bit, trial subtract
    assign w_shift = {i_stage.rem, i_stage.quo[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, i_stage.div};

    always_comb begin
        n_data = i_stage;
        if (!w_diff[WIDTH]) begin
            n_data.rem = w_diff[WIDTH-1:0];
            n_data.quo = {i_stage.quo[WIDTH-2:0], 1'b1};
        end else begin
            n_data.rem = w_shift[WIDTH-1:0];
            n_data.quo = {i_stage.quo[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage.valid) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_stage       = r_data;
        o_stage.valid = r_valid;
    end

endmodule

// File: hdl/sd32_post.sv
module sd32_post
    import sd32_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_out   o_data
);

    logic             r_valid;
    t_out             r_data;
    t_out             n_data;
    logic [WIDTH-1:0] w_q;
    logic [WIDTH-1:0] w_r;

    assign w_q = i_stage.q_neg ? (~i_stage.quo + 1'b1) : i_stage.quo;
    assign w_r = i_stage.a_neg ? (~i_stage.rem + 1'b1) : i_stage.rem;

    always_comb begin
        if (i_stage.dz) begin
            n_data.quotient       = '0;
            n_data.remainder      = '0;
            n_data.divide_by_zero = 1'b1;
        end else begin
            n_data.quotient       = w_q;
            n_data.remainder      = w_r;
            n_data.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
